>>> rtl/fixed_frame_receiver_unit_defines.svh
// Assertion macros for the fixed frame receiver.
`ifndef FIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define FIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffr assertion failed");
`define FFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffr assertion failed");
`else
`define FFR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ffr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants of the fixed frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

    localparam int FRAME_LENGTH_DEF = 30;
    localparam int PAY_IDX_W        = 5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ST_PAYLOAD   = 2'd0;
    localparam logic [1:0] ST_BAD_DELIM = 2'd1;
    localparam logic [1:0] ST_BAD_SUM   = 2'd2;
    localparam logic [1:0] ST_BAD_DEST  = 2'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd50;
    localparam logic [7:0]  OWN_ADDR_RESET = 8'd113;
    localparam logic [7:0]  DELIM_CHAR     = 8'h23;
    localparam logic [7:0]  ADDR_OFFSET    = 8'h80;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [7:0] data;
        logic       last;
    } cell_data_t;

endpackage
`default_nettype wire

>>> rtl/ffr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffr_item_if / ffr_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ffr_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ffr_result_if #(parameter int IDX_W = ffr_pkg::PAY_IDX_W);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [7:0]       function_code;
    logic [7:0]       sender_address;
    logic [IDX_W-1:0] payload_index;
    logic [7:0]       payload_byte;
    logic             last;

    modport source (output valid, output status, output function_code,
                    output sender_address, output payload_index,
                    output payload_byte, output last, input ready);
    modport sink   (input valid, input status, input function_code,
                    input sender_address, input payload_index,
                    input payload_byte, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/fixed_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_frame_receiver_unit
// Collects fixed-length frames from a byte stream, checks them and drains
// the payload or one error result.
// ----------------------------------------------------------------------------
// Channel  | Role | Transaction
// item     | sink | opcode (byte or millisecond tick), rx_byte
// result   | src  | status, function_code, sender_address, payload_index,
//          |      | payload_byte, last
// cfg      | in   | cfg_we, cfg_index, cfg_data; one register per write
//
// One item is accepted per cycle while item.ready is high; a frame is checked
// in the cycle its last byte is accepted, and its results appear from the next
// cycle, one per cycle while result.ready is high. The byte completing a frame
// waits while results of the previous frame are still queued, unless the last
// of them is taken in the same cycle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module fixed_frame_receiver_unit #(
    parameter int FRAME_LENGTH = ffr_pkg::FRAME_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ffr_item_if.sink                       item,
    ffr_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [ffr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ffr_pkg::*;
    `include "fixed_frame_receiver_unit_defines.svh"

    localparam int CNT_W     = $clog2(FRAME_LENGTH);
    localparam int PAY_COUNT = FRAME_LENGTH - 6;
    localparam int DRAIN_N   = (PAY_COUNT > 1) ? PAY_COUNT : 1;
    localparam int IDX_W     = PAY_IDX_W;
    localparam int CELLS     = FRAME_LENGTH - 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [6:0]       sum_reg;
    logic [6:0]       sum_next;
    logic [15:0]      idle_reg;
    logic [15:0]      idle_next;
    logic [15:0]      timeout_reg;
    logic [15:0]      timeout_next;
    logic [7:0]       own_reg;
    logic [7:0]       own_next;
    logic [7:0]       func_reg;
    logic [7:0]       func_next;
    logic [7:0]       sender_reg;
    logic [7:0]       sender_next;

    logic [7:0]       byte_q [CELLS];
    logic             item_acc;
    logic             byte_acc;
    logic             complete;
    logic             pop;
    logic             drain_busy;
    logic [DRAIN_N-1:0] valid_vec;
    logic [DRAIN_N-1:0] remain_vec;
    logic [6:0]       sum_fin;
    logic [15:0]      idle_inc;
    logic [1:0]       frame_status;
    cell_ctrl_t       cell_ctrl;

    cell_data_t       cell_q    [DRAIN_N];
    logic [IDX_W-1:0] cell_idx  [DRAIN_N];

    assign item_acc = item.valid && item.ready;
    assign byte_acc = item_acc && (item.opcode == OP_BYTE);
    assign complete = byte_acc && (count_reg == CNT_W'(FRAME_LENGTH - 1));
    assign pop      = result.valid && result.ready;

    always_comb
    begin
        remain_vec = valid_vec;
        if (pop)
        begin
            remain_vec[0] = 1'b0;
        end
        drain_busy = |remain_vec;
    end

    assign item.ready = !((count_reg == CNT_W'(FRAME_LENGTH - 1)) && drain_busy);

    generate
        for (genvar i = 0; i < CELLS; i++)
        begin : g_line
            if (i == 0)
            begin : g_head
                ffr_byte_cell u_cell (
                    .clk   (clk),
                    .shift (byte_acc),
                    .d     (item.rx_byte),
                    .q     (byte_q[i])
                );
            end
            else
            begin : g_body
                ffr_byte_cell u_cell (
                    .clk   (clk),
                    .shift (byte_acc),
                    .d     (byte_q[i-1]),
                    .q     (byte_q[i])
                );
            end
        end
    endgenerate

    assign sum_fin = sum_reg + item.rx_byte[6:0];

    always_comb
    begin
        if (item.rx_byte != DELIM_CHAR)
        begin
            frame_status = ST_BAD_DELIM;
        end
        else if ({1'b0, sum_fin} != byte_q[FRAME_LENGTH - 4])
        begin
            frame_status = ST_BAD_SUM;
        end
        else if ((byte_q[FRAME_LENGTH - 2] ^ ADDR_OFFSET) != own_reg)
        begin
            frame_status = ST_BAD_DEST;
        end
        else
        begin
            frame_status = ST_PAYLOAD;
        end
    end

    assign cell_ctrl.load  = complete;
    assign cell_ctrl.shift = pop;

    generate
        for (genvar k = 0; k < DRAIN_N; k++)
        begin : g_drain
            cell_data_t       ld;
            cell_data_t       nb;
            logic [IDX_W-1:0] nb_idx;

            always_comb
            begin
                ld.status = frame_status;
                ld.data   = 8'd0;
                ld.last   = 1'b1;
                ld.valid  = (k == 0);
                if (frame_status == ST_PAYLOAD)
                begin
                    ld.valid = (k < PAY_COUNT);
                    ld.data  = byte_q[(FRAME_LENGTH - 7 - k >= 0) ?
                                      (FRAME_LENGTH - 7 - k) : 0];
                    ld.last  = (k == PAY_COUNT - 1);
                end
            end

            if (k == DRAIN_N - 1)
            begin : g_tail
                assign nb     = '0;
                assign nb_idx = '0;
            end
            else
            begin : g_mid
                assign nb     = cell_q[k+1];
                assign nb_idx = cell_idx[k+1];
            end

            ffr_out_cell #(.IDX_W(IDX_W)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .load_data (ld),
                .load_idx  ((frame_status == ST_PAYLOAD) ? IDX_W'(k) : '0),
                .nb_data   (nb),
                .nb_idx    (nb_idx),
                .q_data    (cell_q[k]),
                .q_idx     (cell_idx[k])
            );

            assign valid_vec[k] = cell_q[k].valid;
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        idle_next    = idle_reg;
        timeout_next = timeout_reg;
        own_next     = own_reg;
        func_next    = func_reg;
        sender_next  = sender_reg;
        idle_inc     = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

        if (item_acc && (item.opcode == OP_TICK))
        begin
            if (idle_inc > timeout_reg)
            begin
                count_next = '0;
                sum_next   = '0;
                idle_next  = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        else if (complete)
        begin
            count_next  = '0;
            sum_next    = '0;
            func_next   = byte_q[FRAME_LENGTH - 3];
            sender_next = byte_q[FRAME_LENGTH - 5];
        end
        else if (byte_acc)
        begin
            count_next = count_reg + CNT_W'(1);
            idle_next  = '0;
            if (count_reg != CNT_W'(2))
            begin
                sum_next = sum_fin;
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT:  timeout_next = cfg_data[15:0];
                CFG_OWN_ADDR: own_next     = cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            idle_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
            own_reg     <= OWN_ADDR_RESET;
        end
        else
        begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            idle_reg    <= idle_next;
            timeout_reg <= timeout_next;
            own_reg     <= own_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        sender_reg <= sender_next;
    end

    assign result.valid          = cell_q[0].valid;
    assign result.status         = cell_q[0].status;
    assign result.function_code  = func_reg;
    assign result.sender_address = sender_reg;
    assign result.payload_index  = cell_idx[0];
    assign result.payload_byte   = cell_q[0].data;
    assign result.last           = cell_q[0].last;

    `FFR_ASSERT_NOW(a_error_is_last, clk, rst_n, result.valid && (result.status != ST_PAYLOAD), result.last)
    `FFR_ASSERT_NOW(a_count_in_frame, clk, rst_n, 1'b1, count_reg <= CNT_W'(FRAME_LENGTH - 1))
    `FFR_ASSERT_NEXT(a_complete_clears, clk, rst_n, complete, count_reg == '0)
    `FFR_ASSERT_NEXT(a_error_shows, clk, rst_n, complete && (frame_status != ST_PAYLOAD), result.valid)
endmodule
`default_nettype wire

>>> rtl/ffr_byte_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffr_byte_cell
// One byte of the frame shift line; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module ffr_byte_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);
    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = shift ? d : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;
endmodule
`default_nettype wire

>>> rtl/ffr_out_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffr_out_cell
// One entry of the result drain line; loaded in parallel, shifted to the head.
// ----------------------------------------------------------------------------
module ffr_out_cell #(
    parameter int IDX_W = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ffr_pkg::cell_ctrl_t    ctrl,
    input  ffr_pkg::cell_data_t    load_data,
    input  logic [IDX_W-1:0]       load_idx,
    input  ffr_pkg::cell_data_t    nb_data,
    input  logic [IDX_W-1:0]       nb_idx,
    output ffr_pkg::cell_data_t    q_data,
    output logic [IDX_W-1:0]       q_idx
);
    import ffr_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    cell_data_t       data_reg;
    cell_data_t       data_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        if (ctrl.load)
        begin
            valid_next = load_data.valid;
            data_next  = load_data;
            idx_next   = load_idx;
        end
        else if (ctrl.shift)
        begin
            valid_next = nb_data.valid;
            data_next  = nb_data;
            idx_next   = nb_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        idx_reg  <= idx_next;
    end

    always_comb
    begin
        q_data       = data_reg;
        q_data.valid = valid_reg;
        q_idx        = idx_reg;
    end
endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed frame receiver testbench
// Feeds received bytes and millisecond ticks through the item channel and
// predicts each frame's outcome: either one error result, or the payload
// bytes in order. Results are checked in order against the prediction, while
// the sender works in bursts and the result side stalls on a rotating pattern.
// Directed frames cover the frame checks, their order of priority and the
// idle timeout; random traffic then runs under several register settings.
// ----------------------------------------------------------------------------
module tb;
    import ffr_pkg::*;

    localparam int FRAME_LEN     = FRAME_LENGTH_DEF;
    localparam int PAYLOAD_FIRST = 5;
    localparam int PAYLOAD_LEN   = FRAME_LEN - 6;
    localparam int DRAIN_CYCLES  = 4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] function_code;
        logic [7:0] sender_address;
        logic [4:0] payload_index;
        logic [7:0] payload_byte;
        logic       last;
    } frame_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ffr_item_if   item_ch();
    ffr_result_if result_ch();

    fixed_frame_receiver_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rx_item_t      pending_items[$];
    frame_result_t expected_results[$];
    rx_item_t      next_item;
    logic [7:0]    frame_buf [FRAME_LEN];
    int unsigned   queued_count = 0;
    int            error_count  = 0;
    logic          item_fire;
    int            gap_left   = 0;
    int            burst_left = 0;
    logic [15:0]   stall_cycle = '0;

    logic [7:0]  rx_frame [FRAME_LEN];
    int          rx_count;
    logic [6:0]  rx_sum;
    logic [15:0] rx_idle;
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_addr;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL fixed_frame_receiver_unit");
        $finish;
    end

    function automatic string fmt_result(input frame_result_t r);
        return $sformatf("status=%0d func=%02h sender=%02h idx=%0d byte=%02h last=%0d",
                         r.status, r.function_code, r.sender_address,
                         r.payload_index, r.payload_byte, r.last);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compute_frame_results(input logic op, input logic [7:0] b);
        frame_result_t r;
        logic [1:0]    st;
        logic [7:0]    dest;
        int            i;
        if (op == OP_TICK) begin
            if (rx_idle != IDLE_MAX)
                rx_idle = rx_idle + 16'd1;
            if (rx_idle > cfg_timeout) begin
                rx_count = 0;
                rx_sum   = '0;
                rx_idle  = '0;
            end
        end else begin
            rx_frame[rx_count] = b;
            if (rx_count != 2)
                rx_sum = rx_sum + b[6:0];
            rx_count++;
            if (rx_count < FRAME_LEN) begin
                rx_idle = '0;
            end else begin
                dest = rx_frame[0] + ADDR_OFFSET;
                if (rx_frame[FRAME_LEN-1] != DELIM_CHAR)
                    st = ST_BAD_DELIM;
                else if ({1'b0, rx_sum} != rx_frame[2])
                    st = ST_BAD_SUM;
                else if (dest != cfg_addr)
                    st = ST_BAD_DEST;
                else
                    st = ST_PAYLOAD;
                r.function_code  = rx_frame[1];
                r.sender_address = rx_frame[3];
                if (st != ST_PAYLOAD) begin
                    r.status        = st;
                    r.payload_index = '0;
                    r.payload_byte  = '0;
                    r.last          = 1'b1;
                    expected_results.insert(expected_results.size(), r);
                end else begin
                    for (i = 0; i < PAYLOAD_LEN; i++) begin
                        r.status        = ST_PAYLOAD;
                        r.payload_index = 5'(i);
                        r.payload_byte  = rx_frame[PAYLOAD_FIRST + i];
                        r.last          = (i == PAYLOAD_LEN - 1);
                        expected_results.insert(expected_results.size(), r);
                    end
                end
                rx_count = 0;
                rx_sum   = '0;
            end
        end
    endtask

    task automatic check_result();
        frame_result_t got;
        frame_result_t want;
        got.status         = result_ch.status;
        got.function_code  = result_ch.function_code;
        got.sender_address = result_ch.sender_address;
        got.payload_index  = result_ch.payload_index;
        got.payload_byte   = result_ch.payload_byte;
        got.last           = result_ch.last;
        if (expected_results.size() == 0) begin
            note_error({"unexpected result ", fmt_result(got)});
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.function_code !== want.function_code ||
                got.sender_address !== want.sender_address ||
                got.payload_index !== want.payload_index ||
                got.payload_byte !== want.payload_byte || got.last !== want.last)
                note_error({"expected ", fmt_result(want), " got ", fmt_result(got)});
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_fire <= 1'b0;
        end else begin
            item_fire <= item_ch.valid && item_ch.ready;
            if (result_ch.valid && result_ch.ready)
                check_result();
            if (item_ch.valid && item_ch.ready)
                compute_frame_results(item_ch.opcode, item_ch.rx_byte);
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_fire) begin
            if (gap_left != 0) begin
                gap_left      <= gap_left - 1;
                item_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                item_ch.valid   <= 1'b1;
                item_ch.opcode  <= next_item.opcode;
                item_ch.rx_byte <= next_item.rx_byte;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        stall_cycle <= stall_cycle + 16'd1;
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            case (stall_cycle[8:7])
                2'd0:    result_ch.ready <= 1'b1;
                2'd1:    result_ch.ready <= ($urandom_range(0, 3) != 0);
                2'd2:    result_ch.ready <= (stall_cycle % 5 == 0);
                default: result_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    task automatic queue_item(input logic op, input logic [7:0] b);
        rx_item_t it;
        it.opcode  = op;
        it.rx_byte = b;
        pending_items.insert(pending_items.size(), it);
        queued_count++;
    endtask

    task automatic queue_ticks(input int count);
        int i;
        for (i = 0; i < count; i++)
            queue_item(OP_TICK, 8'($urandom));
    endtask

    task automatic queue_bytes(input int first, input int count, input bit spread);
        int i;
        int most;
        most = (cfg_timeout < 3) ? int'(cfg_timeout) : 3;
        for (i = first; i < first + count; i++) begin
            if (spread && most != 0 && $urandom_range(0, 9) == 0)
                queue_ticks($urandom_range(1, most));
            queue_item(OP_BYTE, frame_buf[i]);
        end
    endtask

    task automatic fix_checksum();
        logic [6:0] sum;
        int         i;
        sum = '0;
        for (i = 0; i < FRAME_LEN; i++)
            if (i != 2)
                sum = sum + frame_buf[i][6:0];
        frame_buf[2] = {1'b0, sum};
    endtask

    task automatic make_frame(input logic [7:0] addr, input logic [1:0] fault);
        int i;
        frame_buf[0] = addr + ADDR_OFFSET;
        for (i = 1; i < FRAME_LEN - 1; i++)
            frame_buf[i] = 8'($urandom);
        frame_buf[FRAME_LEN-1] = DELIM_CHAR;
        if (fault == ST_BAD_DELIM) begin
            do
                frame_buf[FRAME_LEN-1] = 8'($urandom);
            while (frame_buf[FRAME_LEN-1] == DELIM_CHAR);
        end
        if (fault == ST_BAD_DEST)
            frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
        fix_checksum();
        if (fault == ST_BAD_SUM)
            frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] timeout, input logic [7:0] addr);
        wait_drained();
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_OWN_ADDR, {8'($urandom), addr});
        cfg_timeout = timeout;
        cfg_addr    = addr;
    endtask

    task automatic random_traffic(input int target);
        int unsigned start_count;
        int          pick;
        int          i;
        start_count = queued_count;
        while (queued_count - start_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                make_frame(cfg_addr, ST_PAYLOAD);
                queue_bytes(0, FRAME_LEN, 1'b1);
            end else if (pick < 75) begin
                make_frame(cfg_addr, 2'($urandom_range(1, 3)));
                queue_bytes(0, FRAME_LEN, 1'b1);
            end else if (pick < 90 && cfg_timeout < 200) begin
                make_frame(cfg_addr, ST_PAYLOAD);
                if (pick < 83) begin
                    queue_bytes(0, $urandom_range(1, FRAME_LEN - 1), 1'b0);
                end else begin
                    for (i = $urandom_range(1, 5); i > 0; i--)
                        queue_item(OP_BYTE, 8'($urandom));
                end
                queue_ticks(int'(cfg_timeout) + 1 + $urandom_range(0, 2));
            end else begin
                queue_ticks($urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        int i;
        item_ch.valid   = 1'b0;
        item_ch.opcode  = OP_BYTE;
        item_ch.rx_byte = '0;
        result_ch.ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_TIMEOUT;
        cfg_data        = '0;
        rst_n           = 1'b0;
        cfg_timeout     = TIMEOUT_RESET;
        cfg_addr        = OWN_ADDR_RESET;
        rx_count        = 0;
        rx_sum          = '0;
        rx_idle         = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Good frames with extreme header and payload values.
        make_frame(cfg_addr, ST_PAYLOAD);
        frame_buf[1] = 8'hFF;
        frame_buf[3] = 8'h00;
        for (i = 0; i < PAYLOAD_LEN; i++)
            frame_buf[PAYLOAD_FIRST + i] = i[0] ? 8'hFF : 8'h00;
        fix_checksum();
        queue_bytes(0, FRAME_LEN, 1'b0);
        make_frame(cfg_addr, ST_PAYLOAD);
        frame_buf[1] = 8'h00;
        frame_buf[3] = 8'hFF;
        for (i = 0; i < PAYLOAD_LEN; i++)
            frame_buf[PAYLOAD_FIRST + i] = i[0] ? 8'h00 : 8'hFF;
        fix_checksum();
        queue_bytes(0, FRAME_LEN, 1'b0);

        // Each check failing alone, a checksum byte with its top bit set,
        // and two failures at once where the earlier check must win.
        make_frame(cfg_addr, ST_BAD_DELIM);
        queue_bytes(0, FRAME_LEN, 1'b0);
        make_frame(cfg_addr, ST_PAYLOAD);
        frame_buf[2] = frame_buf[2] | 8'h80;
        queue_bytes(0, FRAME_LEN, 1'b0);
        make_frame(cfg_addr, ST_BAD_DEST);
        queue_bytes(0, FRAME_LEN, 1'b0);
        make_frame(cfg_addr, ST_BAD_DELIM);
        frame_buf[2] = frame_buf[2] ^ 8'h01;
        queue_bytes(0, FRAME_LEN, 1'b0);
        make_frame(cfg_addr, ST_BAD_DEST);
        frame_buf[2] = frame_buf[2] ^ 8'h01;
        queue_bytes(0, FRAME_LEN, 1'b0);

        // Timeout just exceeded drops the partial frame; exactly reached keeps it;
        // a received byte restarts the idle count.
        set_config(16'd2, cfg_addr);
        make_frame(cfg_addr, ST_PAYLOAD);
        queue_bytes(0, 4, 1'b0);
        queue_ticks(3);
        make_frame(cfg_addr, ST_PAYLOAD);
        queue_bytes(0, FRAME_LEN, 1'b0);
        make_frame(cfg_addr, ST_PAYLOAD);
        queue_bytes(0, 10, 1'b0);
        queue_ticks(2);
        queue_bytes(10, FRAME_LEN - 10, 1'b0);
        make_frame(cfg_addr, ST_PAYLOAD);
        queue_bytes(0, 5, 1'b0);
        queue_ticks(2);
        queue_bytes(5, 1, 1'b0);
        queue_ticks(2);
        queue_bytes(6, FRAME_LEN - 6, 1'b0);

        set_config(16'd0, 8'd0);
        random_traffic(20);

        // With the largest timeout nothing is dropped.
        set_config(16'hFFFF, 8'hFF);
        random_traffic(10);

        set_config(16'($urandom_range(1, 6)), 8'($urandom));
        random_traffic(20);

        wait_drained();
        repeat (12) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS fixed_frame_receiver_unit");
        else
            $display("FAIL fixed_frame_receiver_unit");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/ffr_pkg.sv
rtl/ffr_if.sv
rtl/ffr_byte_cell.sv
rtl/ffr_out_cell.sv
rtl/fixed_frame_receiver_unit.sv
test/tb.sv
